// ===== hw/rtl/tpc_pkg.sv =====
// Shared types and constants for the temperature and pressure compensation pipeline.
`default_nettype none
package tpc_pkg;

  localparam int RAW_W      = 20;
  localparam int IN_TDATA_W = 40;
  localparam int OUT_TDATA_W = 104;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIV_STAGES = 64;
  localparam int PRE_STAGES = 9;
  localparam int NSTG       = PRE_STAGES + DIV_STAGES + 4;

  localparam logic signed [63:0] T_OFFSET   = 64'sd128000;
  localparam logic signed [63:0] P_SCALE    = 64'sd3125;
  localparam logic signed [63:0] P_FULL     = 64'sd1048576;
  localparam logic signed [63:0] P_BIAS     = 64'sd1 <<< 47;
  localparam logic signed [63:0] SAT_MAX    = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SAT_MIN    = -64'sh0000_0000_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CALIB = 3'd0,
    REG_PRESS_A    = 3'd1,
    REG_PRESS_B    = 3'd2,
    REG_PRESS_C    = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] tc;
    logic signed [31:0] tf;
    logic               dz;
    logic               qneg;
  } side_t;

endpackage
`default_nettype wire

// ===== hw/rtl/temp_pressure_compensation.sv =====
// Top level: pipelined integer temperature and pressure compensation.
// Throughput: one request per cycle; the whole pipeline holds while the output is stalled.
// The 64-step signed divider (one quotient bit per stage) sets the depth.
// Reset: synchronous active-low rst_n clears all valid bits and calibration registers.
`default_nettype none
module temp_pressure_compensation import tpc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // raw_temp[19:0], raw_press[39:20]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // temp_centi, fine_temp, press_q24_8, div_zero, pad
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [47:0] temp_calib_r;
  logic [63:0] press_a_r, press_b_r;
  logic [15:0] press_c_r;

  logic [NSTG-1:0] vld_r;
  logic en;

  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;
  assign out_tvalid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_CALIB: temp_calib_r <= cfg_data[47:0];
        REG_PRESS_A:    press_a_r    <= cfg_data;
        REG_PRESS_B:    press_b_r    <= cfg_data;
        REG_PRESS_C:    press_c_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  // calibration words
  logic        [31:0] t1;
  logic signed [31:0] t2, t3;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, temp_calib_r[15:0]};
  assign t2 = 32'(signed'(temp_calib_r[31:16]));
  assign t3 = 32'(signed'(temp_calib_r[47:32]));
  assign p1 = {48'd0, press_a_r[15:0]};
  assign p2 = 64'(signed'(press_a_r[31:16]));
  assign p3 = 64'(signed'(press_a_r[47:32]));
  assign p4 = 64'(signed'(press_a_r[63:48]));
  assign p5 = 64'(signed'(press_b_r[15:0]));
  assign p6 = 64'(signed'(press_b_r[31:16]));
  assign p7 = 64'(signed'(press_b_r[47:32]));
  assign p8 = 64'(signed'(press_b_r[63:48]));
  assign p9 = 64'(signed'(press_c_r));

  logic [RAW_W-1:0] raw_temp, raw_press;
  assign raw_temp  = in_tdata[RAW_W-1:0];
  assign raw_press = in_tdata[2*RAW_W-1:RAW_W];

  logic signed [31:0] d1, d2;
  assign d1 = signed'(32'(raw_temp >> 3) - (t1 << 1));
  assign d2 = signed'(32'(raw_temp >> 4) - t1);

  // front stages
  logic signed [31:0] s1_m1_r, s1_m2_r, s2_v1t_r, s2_m3_r, s3_tf_r, s4_tf_r, s4_tc_r;
  logic [RAW_W-1:0]   s1_rp_r, s2_rp_r, s3_rp_r, s4_rp_r, s5_rp_r, s6_rp_r, s7_rp_r;
  logic signed [34:0] s4_v_r;
  logic signed [63:0] s5_sq_r, s5_a5_r, s5_a2_r;
  logic signed [63:0] s6_v2a_r, s6_v1a_r, s6_a5_r, s6_a2_r;
  logic signed [63:0] s7_v2_r, s7_v1b_r;
  logic signed [63:0] s8_v1c_r, s8_num_r;
  side_t s5_sd_r, s6_sd_r, s7_sd_r, s8_sd_r;

  logic signed [31:0] m2_sh, tf_sum, tc5;
  logic signed [63:0] pdiff;
  assign m2_sh  = s1_m2_r >>> 12;
  assign tf_sum = s2_v1t_r + (s2_m3_r >>> 14);
  assign tc5    = s3_tf_r * 32'sd5 + 32'sd128;
  assign pdiff  = P_FULL - 64'(s7_rp_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1_r  <= d1 * t2;
      s1_m2_r  <= d2 * d2;
      s1_rp_r  <= raw_press;
      s2_v1t_r <= s1_m1_r >>> 11;
      s2_m3_r  <= m2_sh * t3;
      s2_rp_r  <= s1_rp_r;
      s3_tf_r  <= tf_sum;
      s3_rp_r  <= s2_rp_r;
      s4_tf_r  <= s3_tf_r;
      s4_tc_r  <= tc5 >>> 8;
      s4_v_r   <= 35'(s3_tf_r) - 35'(T_OFFSET);
      s4_rp_r  <= s3_rp_r;
      s5_sq_r  <= 64'(s4_v_r) * 64'(s4_v_r);
      s5_a5_r  <= 64'(s4_v_r) * p5;
      s5_a2_r  <= 64'(s4_v_r) * p2;
      s5_rp_r  <= s4_rp_r;
      s5_sd_r  <= '{tc: s4_tc_r, tf: s4_tf_r, dz: 1'b0, qneg: 1'b0};
      s6_v2a_r <= s5_sq_r * p6;
      s6_v1a_r <= s5_sq_r * p3;
      s6_a5_r  <= s5_a5_r;
      s6_a2_r  <= s5_a2_r;
      s6_rp_r  <= s5_rp_r;
      s6_sd_r  <= s5_sd_r;
      s7_v2_r  <= s6_v2a_r + (s6_a5_r <<< 17) + (p4 <<< 35);
      s7_v1b_r <= (s6_v1a_r >>> 8) + (s6_a2_r <<< 12);
      s7_rp_r  <= s6_rp_r;
      s7_sd_r  <= s6_sd_r;
      s8_v1c_r <= (P_BIAS + s7_v1b_r) * p1;
      s8_num_r <= ((pdiff <<< 31) - s7_v2_r) * P_SCALE;
      s8_sd_r  <= s7_sd_r;
    end
  end

  // divider: stage 0 loads magnitudes, stages 1..64 give one quotient bit each
  logic [64:0] drem_r [0:DIV_STAGES];
  logic [63:0] dquo_r [0:DIV_STAGES];
  logic [63:0] dden_r [0:DIV_STAGES];
  side_t       dsd_r  [0:DIV_STAGES];

  logic signed [63:0] den;
  side_t sd9;
  assign den = s8_v1c_r >>> 33;
  always_comb begin
    sd9      = s8_sd_r;
    sd9.dz   = (den == '0);
    sd9.qneg = s8_num_r[63] ^ den[63];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0] <= '0;
      dquo_r[0] <= s8_num_r[63] ? 64'(-s8_num_r) : 64'(s8_num_r);
      dden_r[0] <= den[63] ? 64'(-den) : 64'(den);
      dsd_r[0]  <= sd9;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [64:0] rsh;
    logic [64:0] rdf;
    assign rsh = {drem_r[k][63:0], dquo_r[k][63]};
    assign rdf = rsh - {1'b0, dden_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k+1] <= rdf[64] ? rsh : rdf;
        dquo_r[k+1] <= {dquo_r[k][62:0], !rdf[64]};
        dden_r[k+1] <= dden_r[k];
        dsd_r[k+1]  <= dsd_r[k];
      end
    end
  end

  // back stages
  logic signed [63:0] q;
  assign q = dsd_r[DIV_STAGES].qneg ? -signed'(dquo_r[DIV_STAGES])
                                    : signed'(dquo_r[DIV_STAGES]);

  logic signed [63:0] sa_p_r, sa_ps_r, sa_x_r, sa_w_r;
  logic signed [63:0] sb_p_r, sb_w_r;
  logic        [63:0] sb_ll_r;
  logic        [31:0] sb_lh_r, sb_hl_r;
  logic signed [63:0] sc_s_r;
  side_t sa_sd_r, sb_sd_r, sc_sd_r;

  logic signed [63:0] sa_ps, y, r;
  logic signed [31:0] press;
  assign sa_ps = q >>> 13;
  assign y     = signed'(sb_ll_r + {sb_lh_r + sb_hl_r, 32'd0});
  assign r     = (sc_s_r >>> 8) + (p7 <<< 4);

  always_comb begin
    if (sc_sd_r.dz)      press = '0;
    else if (r > SAT_MAX) press = 32'sh7FFF_FFFF;
    else if (r < SAT_MIN) press = 32'sh8000_0000;
    else                 press = r[31:0];
  end

  logic [OUT_TDATA_W-1:0] out_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sa_p_r  <= q;
      sa_ps_r <= sa_ps;
      sa_x_r  <= p9 * sa_ps;
      sa_w_r  <= p8 * q;
      sa_sd_r <= dsd_r[DIV_STAGES];
      sb_ll_r <= 64'(sa_x_r[31:0]) * 64'(sa_ps_r[31:0]);
      sb_lh_r <= sa_x_r[31:0] * sa_ps_r[63:32];
      sb_hl_r <= sa_x_r[63:32] * sa_ps_r[31:0];
      sb_p_r  <= sa_p_r;
      sb_w_r  <= sa_w_r;
      sb_sd_r <= sa_sd_r;
      sc_s_r  <= sb_p_r + (y >>> 25) + (sb_w_r >>> 19);
      sc_sd_r <= sb_sd_r;
      out_r   <= {7'd0, sc_sd_r.dz, press, sc_sd_r.tf, sc_sd_r.tc};
    end
  end

  assign out_tdata = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tpc_checker.sv =====
// Port-level checker for the compensation pipeline, bound to the top level.
`default_nettype none
module tpc_checker import tpc_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output request changed while stalled");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[96] |-> out_tdata[95:64] == '0)
    else $error("pressure not zero on zero divisor");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind temp_pressure_compensation tpc_checker u_tpc_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// ===== verif/tb_temp_pressure_compensation.sv =====
// Testbench for temp_pressure_compensation: random calibration, streams and backpressure.
`default_nettype none
module tb_temp_pressure_compensation;
  import tpc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY    = 77;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 400;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd4;

  typedef struct {
    logic signed [31:0] temp_centi;
    logic signed [31:0] fine_temp;
    logic signed [31:0] press_q24_8;
    logic               div_zero;
  } comp_res_t;

  class comp_scoreboard;
    logic [47:0] temp_calib;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [15:0] press_c;
    comp_res_t   pending[$];

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        REG_TEMP_CALIB: temp_calib = val[47:0];
        REG_PRESS_A:    press_a = val;
        REG_PRESS_B:    press_b = val;
        REG_PRESS_C:    press_c = val[15:0];
        default: ;
      endcase
    endfunction

    function logic signed [63:0] sx16(logic [15:0] w);
      return {{48{w[15]}}, w};
    endfunction

    function logic [63:0] div_trunc(logic [63:0] n, logic [63:0] d);
      logic [63:0] an, ad, q;
      an = n[63] ? -n : n;
      ad = d[63] ? -d : d;
      q = an / ad;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    function comp_res_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      comp_res_t r;
      logic [31:0] t1, t2, t3, d1, v1t, d2, sq, v2t, tf, tc;
      logic signed [63:0] v1, v2, p, ps, bias;
      logic [63:0] q;
      t1 = {16'd0, temp_calib[15:0]};
      t2 = {{16{temp_calib[31]}}, temp_calib[31:16]};
      t3 = {{16{temp_calib[47]}}, temp_calib[47:32]};
      d1 = ({12'd0, raw_t} >> 3) - (t1 << 1);
      v1t = $signed(d1 * t2) >>> 11;
      d2 = ({12'd0, raw_t} >> 4) - t1;
      sq = $signed(d2 * d2) >>> 12;
      v2t = $signed(sq * t3) >>> 14;
      tf = v1t + v2t;
      tc = $signed(tf * 32'd5 + 32'd128) >>> 8;
      r.temp_centi = tc;
      r.fine_temp = tf;
      v1 = {{32{tf[31]}}, tf};
      v1 = v1 - T_OFFSET;
      v2 = v1 * v1 * sx16(press_b[31:16]);
      v2 = v2 + ((v1 * sx16(press_b[15:0])) <<< 17);
      v2 = v2 + (sx16(press_a[63:48]) <<< 35);
      v1 = ((v1 * v1 * sx16(press_a[47:32])) >>> 8) + ((v1 * sx16(press_a[31:16])) <<< 12);
      bias = P_BIAS;
      v1 = ((bias + v1) * $signed({48'd0, press_a[15:0]})) >>> 33;
      if (v1 == 0) begin
        r.press_q24_8 = 0;
        r.div_zero = 1'b1;
      end else begin
        p = P_FULL - $signed({44'd0, raw_p});
        q = div_trunc(((p <<< 31) - v2) * P_SCALE, v1);
        p = q;
        ps = p >>> 13;
        v1 = (sx16(press_c) * ps * ps) >>> 25;
        v2 = (sx16(press_b[63:48]) * p) >>> 19;
        p = ((p + v1 + v2) >>> 8) + (sx16(press_b[47:32]) <<< 4);
        if (p > SAT_MAX) r.press_q24_8 = 32'h7FFF_FFFF;
        else if (p < SAT_MIN) r.press_q24_8 = 32'h8000_0000;
        else r.press_q24_8 = p[31:0];
        r.div_zero = 1'b0;
      end
      return r;
    endfunction

    function void note_reading(logic [19:0] raw_t, logic [19:0] raw_p);
      pending.push_back(compensate(raw_t, raw_p));
    endfunction

    function string check_result(logic [OUT_TDATA_W-1:0] d);
      comp_res_t e;
      string s;
      if (pending.size() == 0) return $sformatf("unexpected result %h", d);
      e = pending.pop_front();
      s = "";
      if (d[31:0] !== e.temp_centi)
        s = {s, $sformatf(" temp_centi got %0d exp %0d", $signed(d[31:0]), e.temp_centi)};
      if (d[63:32] !== e.fine_temp)
        s = {s, $sformatf(" fine_temp got %0d exp %0d", $signed(d[63:32]), e.fine_temp)};
      if (d[95:64] !== e.press_q24_8)
        s = {s, $sformatf(" press got %0d exp %0d", $signed(d[95:64]), e.press_q24_8)};
      if (d[96] !== e.div_zero)
        s = {s, $sformatf(" div_zero got %b exp %b", d[96], e.div_zero)};
      return s;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tready = 0;
  logic cfg_valid = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire in_tready, out_tvalid, cfg_ready;
  wire [OUT_TDATA_W-1:0] out_tdata;

  comp_scoreboard sb = new();
  int  n_errors = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  int  stall_mode = 0;
  int  mode_left = 0;

  temp_pressure_compensation u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] mismatch:%s", $realtime, msg);
  endtask

  // receiver: check, then choose ready for the next cycle
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      msg = sb.check_result(out_tdata);
      if (msg != "") report_mismatch(msg);
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(10, 80);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_calib(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb, logic [15:0] pc);
    write_cfg(REG_TEMP_CALIB, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | tc);
    write_cfg(REG_PRESS_A, pa);
    write_cfg(REG_PRESS_B, pb);
    write_cfg(REG_PRESS_C, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | pc);
  endtask

  // send one reading; valid stays high until the caller drops it
  task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p);
    in_tvalid <= 1'b1;
    in_tdata <= {raw_p, raw_t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_reading(raw_t, raw_p);
  endtask

  task automatic send_random(int count, bit realistic);
    int burst;
    logic [19:0] rt, rp;
    burst = 0;
    for (int i = 0; i < count; i++) begin
      if (burst == 0) burst = $urandom_range(1, 30);
      burst--;
      if (realistic && $urandom_range(0, 3) != 0) begin
        rt = 20'($urandom_range(400000, 600000));
        rp = 20'($urandom_range(250000, 450000));
      end else begin
        rt = 20'($urandom);
        rp = 20'($urandom);
      end
      send_reading(rt, rp);
      if (burst == 0 && $urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic send_directed();
    logic [19:0] vals[6];
    vals = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'h6B4A0, 20'h00001};
    for (int i = 0; i < 6; i++)
      send_reading(vals[i], vals[5 - i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  localparam logic [47:0] TYP_T = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_A = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
  localparam logic [63:0] TYP_B = {-16'sd14600, 16'd15500, -16'sd7, 16'd140};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset calibration: zero divisor everywhere
    send_directed();
    drain();
    set_calib(TYP_T, TYP_A, TYP_B, 16'd6000);
    write_cfg(IDX_SPARE_LO, '1);
    write_cfg(IDX_SPARE_LO + 3'd3, '1);
    send_directed();
    hold_req <= 1'b1;
    send_random(300, 1);
    drain();
    set_calib('1, '1, '1, 16'hFFFF);
    send_directed();
    send_random(150, 0);
    drain();
    set_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
              {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF);
    send_directed();
    send_random(150, 0);
    drain();
    set_calib({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
              {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
    send_directed();
    send_random(150, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0)
        set_calib(TYP_T ^ ($urandom & 32'h0000_03FF), TYP_A ^ {$urandom, $urandom} & 64'h00FF_00FF_00FF_0FFF,
                  TYP_B ^ {$urandom, $urandom} & 64'h00FF_00FF_000F_00FF, 16'($urandom));
      else
        set_calib(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
      send_random(100, ph % 2 == 0);
      drain();
    end
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
